// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the terminal RTL. Every check is clocked
// on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define TTCS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds whenever the antecedent does.
`define TTCS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ttcs_pkg.sv =====
// ----------------------------------------------------------------------------
// ttcs_pkg
// Types and constants for the ring-scrolled text terminal.
// ----------------------------------------------------------------------------
package ttcs_pkg;

    // Screen geometry
    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int DEPTH  = ROWS * COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    // Field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    // Special characters
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

    // Operation codes
    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_DEL   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // Command item
    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } cmd_t;

    // Result item
    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [ROW_W-1:0]  top_row;
        logic              scrolled;
        logic [CHAR_W-1:0] read_char;
    } res_t;

endpackage

// ===== rtl/core/text_terminal_cursor_scroll.sv =====
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll
// Text terminal with a ring of character rows, a top-row index and a cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Command items arrive on cmd (cmd_valid / cmd_stall); each gives exactly
//   one result item on res (res_valid / res_stall). One command is worked on
//   at a time; cmd_stall is high from acceptance until the sequencer is idle.
//   Steps from acceptance to result ready, all through one address unit and
//   the single store port:
//     put, new line, out-of-range read, delete at origin : EXEC, DONE
//     delete, in-range read                              : EXEC, DEL or RDWAIT, DONE
//     any move that scrolls                              : EXEC, FILL per cell, DONE
//     clear                                              : EXEC, CLEAR per cell, DONE
//   The next item can be taken the cycle after a result is loaded; no item is
//   taken before then, and a result waits to load while res is stalled.
//   Scroll blanks the new bottom row one cell a cycle; clear and reset zero
//   the whole store one cell a cycle.
//   After reset the block runs a clearing pass over all ROWS*COLS (2000) cells
//   with cmd_stall high before it takes the first item.
//   Results sit in an output register; a new command is accepted while the
//   last result waits under res_stall, and its own result waits in turn.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_terminal_cursor_scroll
    import ttcs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_DEL,
        S_RDWAIT,
        S_FILL,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  line_reg, line_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [COL_W-1:0]  fill_col_reg, fill_col_next;
    logic [ROW_W-1:0]  fill_line_reg, fill_line_next;
    logic              clr_op_reg, clr_op_next;
    logic              scrolled_reg, scrolled_next;
    logic [CHAR_W-1:0] rd_reg, rd_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] mem_q_reg;

    logic [ROW_W-1:0]  au_top;
    logic [ROW_W-1:0]  au_line;
    logic [COL_W-1:0]  au_col;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic              mem_re;
    logic [CHAR_W-1:0] mem_wdata;
    logic              accept;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Steer the shared address unit
    always_comb
    begin
        au_top  = top_reg;
        au_line = line_reg;
        au_col  = col_reg;
        if (state_reg == S_CLEAR)
        begin
            au_top  = '0;
            au_line = fill_line_reg;
            au_col  = fill_col_reg;
        end
        else if (state_reg == S_FILL)
        begin
            au_line = LAST_ROW;
            au_col  = fill_col_reg;
        end
        else if (state_reg == S_EXEC && cmd_reg.op == OP_READ)
        begin
            au_line = cmd_reg.read_row;
            au_col  = cmd_reg.read_col;
        end
    end

    ttcs_addr_unit u_addr (
        .top  (au_top),
        .line (au_line),
        .col  (au_col),
        .addr (mem_addr)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        col_next       = col_reg;
        line_next      = line_reg;
        top_next       = top_reg;
        fill_col_next  = fill_col_reg;
        fill_line_next = fill_line_reg;
        clr_op_next    = clr_op_reg;
        scrolled_next  = scrolled_reg;
        rd_next        = rd_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wdata      = '0;

        // Drop the held result once taken
        res_valid_next = res_valid_reg && res_stall;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (fill_col_reg == LAST_COL)
                begin
                    fill_col_next = '0;
                    if (fill_line_reg == LAST_ROW)
                    begin
                        fill_line_next = '0;
                        state_next     = clr_op_reg ? S_DONE : S_IDLE;
                    end
                    else
                    begin
                        fill_line_next = fill_line_reg + 1'b1;
                    end
                end
                else
                begin
                    fill_col_next = fill_col_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next      = cmd;
                    scrolled_next = 1'b0;
                    rd_next       = '0;
                    state_next    = S_EXEC;
                end
            end

            S_EXEC:
            begin
                unique case (cmd_reg.op)
                    OP_PUT:
                    begin
                        if (cmd_reg.char_code == CH_LF || cmd_reg.char_code == CH_CR
                            || col_reg == LAST_COL)
                        begin
                            // Store the character unless it is a line break
                            if (cmd_reg.char_code != CH_LF && cmd_reg.char_code != CH_CR)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = cmd_reg.char_code;
                            end
                            col_next = '0;
                            if (line_reg == LAST_ROW)
                            begin
                                // Advance the top; the old top row becomes the bottom
                                top_next      = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
                                scrolled_next = 1'b1;
                                fill_col_next = '0;
                                state_next    = S_FILL;
                            end
                            else
                            begin
                                line_next  = line_reg + 1'b1;
                                state_next = S_DONE;
                            end
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_wdata  = cmd_reg.char_code;
                            col_next   = col_reg + 1'b1;
                            state_next = S_DONE;
                        end
                    end

                    OP_DEL:
                    begin
                        if (col_reg == '0 && line_reg == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            if (col_reg == '0)
                            begin
                                line_next = line_reg - 1'b1;
                                col_next  = LAST_COL;
                            end
                            else
                            begin
                                col_next = col_reg - 1'b1;
                            end
                            state_next = S_DEL;
                        end
                    end

                    OP_CLEAR:
                    begin
                        col_next       = '0;
                        line_next      = '0;
                        top_next       = '0;
                        fill_col_next  = '0;
                        fill_line_next = '0;
                        clr_op_next    = 1'b1;
                        state_next     = S_CLEAR;
                    end

                    OP_READ:
                    begin
                        if (cmd_reg.read_row < ROW_W'(ROWS) && cmd_reg.read_col < COL_W'(COLS))
                        begin
                            mem_re     = 1'b1;
                            state_next = S_RDWAIT;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_DEL:
            begin
                mem_we     = 1'b1;
                mem_wdata  = '0;
                state_next = S_DONE;
            end

            S_RDWAIT:
            begin
                rd_next    = mem_q_reg;
                state_next = S_DONE;
            end

            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = CH_SPACE;
                if (fill_col_reg == LAST_COL)
                begin
                    fill_col_next = '0;
                    state_next    = S_DONE;
                end
                else
                begin
                    fill_col_next = fill_col_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                // Load the result once the output register is free
                if (!res_valid_reg || !res_stall)
                begin
                    res_next.cursor_col = col_reg;
                    res_next.cursor_row = line_reg;
                    res_next.top_row    = top_reg;
                    res_next.scrolled   = scrolled_reg;
                    res_next.read_char  = rd_reg;
                    res_valid_next      = 1'b1;
                    clr_op_next         = 1'b0;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cmd_reg       <= '0;
            col_reg       <= '0;
            line_reg      <= '0;
            top_reg       <= '0;
            fill_col_reg  <= '0;
            fill_line_reg <= '0;
            clr_op_reg    <= 1'b0;
            scrolled_reg  <= 1'b0;
            rd_reg        <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            col_reg       <= col_next;
            line_reg      <= line_next;
            top_reg       <= top_next;
            fill_col_reg  <= fill_col_next;
            fill_line_reg <= fill_line_next;
            clr_op_reg    <= clr_op_next;
            scrolled_reg  <= scrolled_next;
            rd_reg        <= rd_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    // Character store: one port for writes and registered reads
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_addr];
        end
    end

    // Checks
    `TTCS_ASSERT(a_cursor_range,
        (col_reg < COL_W'(COLS) && line_reg < ROW_W'(ROWS) && top_reg < ROW_W'(ROWS)),
        "cursor or top row out of range")
    `TTCS_ASSERT_IMPL(a_fill_at_bottom, (state_reg == S_FILL),
        (line_reg == LAST_ROW && col_reg == '0 && scrolled_reg),
        "scroll fill without cursor at bottom line start")
    `TTCS_ASSERT_IMPL(a_no_idle_write, (state_reg == S_IDLE), (!mem_we && !mem_re),
        "store accessed while idle")
    `TTCS_ASSERT_IMPL(a_result_from_done, $rose(res_valid_reg), ($past(state_reg) == S_DONE),
        "result raised outside the done step")

endmodule

// ===== rtl/core/ttcs_addr_unit.sv =====
// ----------------------------------------------------------------------------
// ttcs_addr_unit
// Shared cell address unit: maps a screen line and column through the row
// ring onto a linear store address.
// ----------------------------------------------------------------------------
module ttcs_addr_unit
    import ttcs_pkg::*;
(
    input  logic [ROW_W-1:0]  top,
    input  logic [ROW_W-1:0]  line,
    input  logic [COL_W-1:0]  col,
    output logic [ADDR_W-1:0] addr
);

    logic [ROW_W:0]   sum;
    logic [ROW_W-1:0] ring;

    // Wrap the ring row with a single compare and subtract
    always_comb
    begin
        sum = {1'b0, top} + {1'b0, line};
        if (sum >= (ROW_W + 1)'(ROWS))
        begin
            ring = ROW_W'(sum - (ROW_W + 1)'(ROWS));
        end
        else
        begin
            ring = sum[ROW_W-1:0];
        end
    end

    // Row base by constant multiply, then add column
    assign addr = ADDR_W'(ring * ADDR_W'(COLS)) + ADDR_W'(col);

endmodule
